// ----- rtl/cst_pkg.sv -----
// Shared types, constants and fixed-point helpers for the similarity transform core.
`default_nettype none
package cst_pkg;
  localparam int NMax = 32;
  localparam int FracBits = 16;
  localparam int IdxW = $clog2(NMax);
  localparam int AddrW = 2 * IdxW;
  localparam int Cells = NMax * NMax;

  typedef enum logic [1:0] {
    OP_LOAD_COEF = 2'd0,
    OP_LOAD_OPER = 2'd1,
    OP_SUB_OPER  = 2'd2,
    OP_QUERY     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SIZE     = 2'd0,
    REG_REAL     = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INNER,
    ST_OUTER,
    ST_FINAL,
    ST_SUB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
  } cplx_t;

  // floor(a*b / 2^FracBits), exact product in 64 bits
  function automatic logic signed [63:0] fmul(input logic signed [63:0] p);
    fmul = p >>> FracBits;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x,
                                               output logic flag);
    flag = 1'b0;
    if (x > 64'sd2147483647) begin
      flag = 1'b1; sat32 = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      flag = 1'b1; sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/cst_ram.sv -----
// Generic single-port-write, single-read synchronous RAM, registered read.
`default_nettype none
module cst_ram #(
  parameter int Depth = 1024,
  parameter int Width = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/cst_mac.sv -----
// Complex multiply-accumulate datapath: inner sum over k, outer sum over l.
`default_nettype none
module cst_mac import cst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        clr_inner,
  input  wire logic        clr_outer,
  input  wire logic        en_inner,   // a = M, b = U column
  input  wire logic        en_outer,   // a = U row entry (conj)
  input  wire cplx_t       a,
  input  wire cplx_t       b,
  output logic signed [63:0] acc_re,
  output logic signed [63:0] acc_im,
  output logic             sat_any
);
  // registered products
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic               pin, pout;
  logic signed [63:0] t_re, t_im;
  logic signed [31:0] ts_re, ts_im;
  logic               f_re, f_im;
  logic signed [31:0] br, bi;

  always_comb begin
    ts_re = sat32(t_re, f_re);
    ts_im = sat32(t_im, f_im);
  end

  // outer step uses saturated inner sum as multiplicand
  assign br = en_outer ? ts_re : $signed(b.re);
  assign bi = en_outer ? ts_im : $signed(b.im);

  always_ff @(posedge clk) begin
    p_rr <= $signed(a.re) * br;
    p_ii <= $signed(a.im) * bi;
    p_ri <= $signed(a.re) * bi;
    p_ir <= $signed(a.im) * br;
    pin  <= en_inner;
    pout <= en_outer;
    if (clr_inner) begin
      t_re <= '0; t_im <= '0;
    end else if (pin) begin
      t_re <= t_re + fmul(p_rr) - fmul(p_ii);
      t_im <= t_im + fmul(p_ri) + fmul(p_ir);
    end
    if (clr_outer) begin
      acc_re <= '0; acc_im <= '0; sat_any <= 1'b0;
    end else if (pout) begin
      acc_re <= acc_re + fmul(p_rr) + fmul(p_ii);
      acc_im <= acc_im + fmul(p_ri) - fmul(p_ir);
    end else if (en_outer) begin
      sat_any <= sat_any | f_re | f_im;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/complex_similarity_transform_core.sv -----
// Top level: request decode, sequencer over the two stores, result register.
// Loads write their store on acceptance; subtract reads, modifies and writes back.
// A query runs, for each l, the inner sum (ST_INNER) then the outer step (ST_OUTER),
//   then finishes through ST_FINAL and ST_DONE before the result is valid.
// An out-of-range query goes from acceptance straight to ST_DONE.
// Reset (rst, synchronous) restores size 32, real_only 0 and idles the sequencer;
//   store contents are undefined until written.
`default_nettype none
module complex_similarity_transform_core import cst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] operation, [6:2] row, [11:7] col, [43:12] value_re, [75:44] value_im
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [4:0] out_row, [9:5] out_col, [57:10] result_re, [105:58] result_im,
  // [106] saturated
  output logic [111:0]     m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);
  logic [5:0] size_in_use;
  logic       real_only;
  state_t     state, state_next;
  op_t        op;
  logic [IdxW-1:0] row, col, qrow, qcol;
  logic [IdxW:0] n, l, k, l_next, k_next;
  logic [AddrW-1:0] entry, qcell;
  cplx_t      val, qval;
  logic       in_range;
  logic [1:0] cnt;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= 6'd32; real_only <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'({1'b0, cfg_index}))
        REG_SIZE: size_in_use <= cfg_data;
        REG_REAL: real_only   <= cfg_data[0];
        default: ;
      endcase
    end
  end
  assign n = (size_in_use == 0) ? (IdxW+1)'(1) :
             (size_in_use > 6'(NMax)) ? (IdxW+1)'(NMax) : size_in_use[IdxW:0];

  assign op   = op_t'(s_tdata[1:0]);
  assign row  = s_tdata[6:2];
  assign col  = s_tdata[11:7];
  assign val  = '{re: s_tdata[43:12], im: s_tdata[75:44]};
  assign entry = {row, col};
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  wire acc = s_tvalid && s_tready;

  // stores
  logic c_we, o_we;
  logic [AddrW-1:0] c_wa, o_wa, c_ra, o_ra;
  cplx_t c_wd, o_wd, c_rd, o_rd;
  cst_ram #(.Depth(Cells), .Width(64)) u_coef (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  cst_ram #(.Depth(Cells), .Width(64)) u_oper (
    .clk, .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  // subtract-modify values
  logic signed [31:0] d_re, d_im;
  logic fd0, fd1;
  always_comb begin
    d_re = sat32(64'($signed(o_rd.re)) - 64'($signed(qval.re)), fd0);
    d_im = sat32(64'($signed(o_rd.im)) - 64'($signed(qval.im)), fd1);
  end

  // next state
  always_comb begin
    state_next = state; l_next = l; k_next = k;
    unique case (state)
      ST_IDLE: if (acc) begin
        if (op == OP_QUERY) begin
          state_next = ({1'b0,row} < n && {1'b0,col} < n) ? ST_INNER : ST_DONE;
          l_next = '0; k_next = '0;
        end else if (op == OP_SUB_OPER) state_next = ST_SUB;
      end
      ST_INNER: if (k == n + 1) begin state_next = ST_OUTER; k_next = '0; end
                else k_next = k + 1'b1;
      ST_OUTER: if (k == 2) begin
        k_next = '0;
        if (l == n - 1'b1) state_next = ST_FINAL;
        else begin state_next = ST_INNER; l_next = l + 1'b1; end
      end else k_next = k + 1'b1;
      ST_FINAL: if (k == 1) state_next = ST_DONE; else k_next = k + 1'b1;
      ST_SUB:   if (cnt == 2'd1) state_next = ST_IDLE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; l <= '0; k <= '0; cnt <= '0;
    end else begin
      state <= state_next; l <= l_next; k <= k_next;
      cnt <= (state == ST_SUB) ? cnt + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      qrow <= row; qcol <= col; qval <= val; qcell <= entry;
      in_range <= ({1'b0,row} < n && {1'b0,col} < n);
    end
  end

  // store control
  always_comb begin
    c_we = acc && (op == OP_LOAD_COEF);
    c_wa = entry; c_wd = val;
    o_we = (acc && (op == OP_LOAD_OPER)) || (state == ST_SUB && cnt == 2'd1);
    o_wa = acc ? entry : qcell;
    o_wd = acc ? val : '{re: d_re, im: d_im};
    o_ra = qcell; c_ra = qcell;
    unique case (state)
      ST_INNER: begin
        o_ra = {l[IdxW-1:0], k[IdxW-1:0]};
        c_ra = {k[IdxW-1:0], qcol};
      end
      ST_OUTER: c_ra = {l[IdxW-1:0], qrow};
      default: ;
    endcase
  end

  // MAC sequencing: RAM data valid in the cycle after its address
  logic inner_v, outer_v, clr_o;
  always_ff @(posedge clk) begin
    inner_v <= (state == ST_INNER) && (k < n);
    outer_v <= (state == ST_OUTER) && (k == 0);
  end
  assign clr_o = acc;
  logic signed [63:0] acc_re, acc_im;
  logic sat_in;
  cst_mac u_mac (
    .clk, .clr_inner(acc || (state == ST_OUTER && k == 2)), .clr_outer(clr_o),
    .en_inner(inner_v), .en_outer(outer_v), .a(inner_v ? o_rd : c_rd),
    .b(c_rd), .acc_re, .acc_im, .sat_any(sat_in));

  // final saturation and output register
  logic signed [47:0] r_re, r_im;
  logic sr, si;
  always_comb begin
    sr = 1'b0; si = 1'b0; r_re = acc_re[47:0]; r_im = acc_im[47:0];
    if (acc_re > 64'sd140737488355327) begin r_re = 48'sh7fffffffffff; sr = 1'b1; end
    else if (acc_re < -64'sd140737488355328) begin r_re = 48'sh800000000000; sr = 1'b1; end
    if (acc_im > 64'sd140737488355327) begin r_im = 48'sh7fffffffffff; si = 1'b1; end
    else if (acc_im < -64'sd140737488355328) begin r_im = 48'sh800000000000; si = 1'b1; end
    if (real_only) begin r_im = '0; si = 1'b0; end
  end

  // result word, pad bits zero, value fields zero when out of range
  logic [111:0] res_word;
  always_comb begin
    res_word = '0;
    res_word[4:0] = qrow;
    res_word[9:5] = qcol;
    if (in_range) begin
      res_word[57:10]  = r_re;
      res_word[105:58] = r_im;
      res_word[106]    = sat_in | sr | si;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (state == ST_DONE) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (state == ST_DONE) m_tdata <= res_word;
  end
endmodule
`default_nettype wire

// ----- rtl/cst_checker.sv -----
// Port-level checker for the similarity transform core, bound to the top level.
`default_nettype none
module cst_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [111:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[111:107] == '0) else $error("pad bits set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("request taken while result pending");
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result after reset");
endmodule
bind complex_similarity_transform_core cst_checker u_chk (.*);
`default_nettype wire
